### sv/jsfx_pkg.sv
package jsfx_pkg;

  // Number of classified items held between the front and back ends
  localparam int QUEUE_DEPTH = 4;

  // Register indexes on the configuration port
  localparam logic [1:0] REG_KEY_LOW  = 2'd0;
  localparam logic [1:0] REG_KEY_HIGH = 2'd1;
  localparam logic [1:0] REG_KEY_LEN  = 2'd2;

  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB = 8'h09;
  localparam logic [7:0] CH_CR = 8'h0D;
  localparam logic [7:0] CH_LF = 8'h0A;

  typedef enum logic [1:0] {
    ST_NOT_FOUND = 2'd0,
    ST_COMPLETE  = 2'd1,
    ST_OPEN      = 2'd2
  } status_t;

  typedef enum logic [5:0] {
    PH_SEARCH = 6'b000001,
    PH_COLON  = 6'b000010,
    PH_SPACE  = 6'b000100,
    PH_VALUE  = 6'b001000,
    PH_ESCAPE = 6'b010000,
    PH_DRAIN  = 6'b100000
  } phase_t;

  // One text byte after classification by the front end
  typedef struct packed {
    logic [7:0] ch;
    logic       last;
    logic       searching;  // front end was still looking for the key
    logic       hit;        // key matched on this byte
  } class_t;

  function automatic logic [7:0] unescape(input logic [7:0] e);
    logic [7:0] r;
    case (e)
      8'h62:   r = 8'h08;  // b
      8'h66:   r = 8'h0C;  // f
      8'h6E:   r = 8'h0A;  // n
      8'h72:   r = 8'h0D;  // r
      8'h74:   r = 8'h09;  // t
      default: r = e;      // quote, backslash, slash and the rest pass through
    endcase
    return r;
  endfunction

endpackage

### sv/jsfx_front.sv
module jsfx_front import jsfx_pkg::*; #(
  parameter int MAX_KEY_BYTES = 16
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         take,
  input  logic [7:0]   text_byte,
  input  logic         text_last,
  input  logic [63:0]  key_low,
  input  logic [63:0]  key_high,
  input  logic [4:0]   key_len,
  output class_t       item
);

  localparam int WD = MAX_KEY_BYTES + 2;
  localparam int IW = $clog2(WD);
  localparam int FW = $clog2(WD + 1);

  logic [7:0]    win [WD];
  logic [7:0]    win_next [WD];
  logic [FW-1:0] fill;
  logic [FW-1:0] fill_next;
  logic          searching;
  logic [4:0]    klen;
  logic [127:0]  key_all;
  logic          match;

  assign key_all = {key_high, key_low};
  assign klen = (key_len > 5'(MAX_KEY_BYTES)) ? 5'(MAX_KEY_BYTES) : key_len;
  assign fill_next = (fill == FW'(WD)) ? fill : fill + FW'(1);

  always_comb begin
    win_next[0] = text_byte;
    for (int i = 1; i < WD; i++) begin
      win_next[i] = win[i-1];
    end
  end

  // Newest byte is the closing quote, the byte k+1 back is the opening one
  always_comb begin
    logic [IW-1:0] idx;
    match = (fill_next >= FW'(klen) + FW'(2)) && (win_next[0] == CH_QUOTE) &&
            (win_next[IW'(klen) + IW'(1)] == CH_QUOTE);
    for (int i = 0; i < MAX_KEY_BYTES; i++) begin
      idx = IW'(klen) - IW'(i);
      if ((5'(i) < klen) && (win_next[idx] != key_all[8*i +: 8])) begin
        match = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= '0;
      searching <= 1'b1;
    end else if (take) begin
      if (text_last) begin
        fill <= '0;
        searching <= 1'b1;
      end else if (searching) begin
        fill <= fill_next;
        if (match) begin
          searching <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take && searching) begin
      for (int i = 0; i < WD; i++) begin
        win[i] <= win_next[i];
      end
    end
  end

  assign item.ch = text_byte;
  assign item.last = text_last;
  assign item.searching = searching;
  assign item.hit = searching && match;

endmodule

### sv/jsfx_queue.sv
module jsfx_queue import jsfx_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   wr,
  input  class_t wr_item,
  input  logic   rd,
  output class_t head,
  output logic   q_empty,
  output logic   q_full
);

  localparam int AW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  class_t        mem [QUEUE_DEPTH];
  logic [AW-1:0] wptr;
  logic [AW-1:0] rptr;
  logic [CW-1:0] count;

  assign q_empty = (count == '0);
  assign q_full = (count == CW'(QUEUE_DEPTH));
  assign head = mem[rptr];

  always_ff @(posedge clk) begin
    if (wr) begin
      mem[wptr] <= wr_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      count <= '0;
    end else begin
      if (wr) begin
        wptr <= (wptr == AW'(QUEUE_DEPTH - 1)) ? '0 : wptr + AW'(1);
      end
      if (rd) begin
        rptr <= (rptr == AW'(QUEUE_DEPTH - 1)) ? '0 : rptr + AW'(1);
      end
      case ({wr, rd})
        2'b10:   count <= count + CW'(1);
        2'b01:   count <= count - CW'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

### sv/jsfx_back.sv
module jsfx_back import jsfx_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  class_t     head,
  input  logic       q_empty,
  output logic       q_rd,
  input  logic       pop,
  output logic       empty,
  output logic [7:0] value_byte,
  output logic       byte_valid,
  output logic       done_res,
  output logic [1:0] status
);

  phase_t     phase;
  phase_t     phase_next;
  logic       out_valid;
  logic       have;
  logic       done;
  logic [7:0] vb;
  status_t    st;

  // Next item is taken when the output register is free or being freed
  assign q_rd = !q_empty && (!out_valid || pop);
  assign empty = !out_valid;

  always_comb begin
    have = 1'b0;
    done = 1'b0;
    vb = 8'h00;
    st = ST_NOT_FOUND;
    phase_next = phase;
    case (phase)
      PH_SEARCH: begin
        if (head.hit) begin
          phase_next = PH_COLON;
        end
        done = head.last;
      end
      PH_COLON: begin
        if (head.ch == CH_COLON) begin
          phase_next = PH_SPACE;
        end
        done = head.last;
      end
      PH_SPACE: begin
        if (head.ch == CH_QUOTE) begin
          phase_next = PH_VALUE;
          if (head.last) begin
            done = 1'b1;
            st = ST_OPEN;
          end
        end else if (head.ch inside {CH_SPACE, CH_TAB, CH_CR, CH_LF}) begin
          done = head.last;
        end else begin
          done = 1'b1;  // anything else where the opening quote belongs
        end
      end
      PH_VALUE: begin
        if (head.ch == CH_QUOTE) begin
          done = 1'b1;
          st = ST_COMPLETE;
        end else begin
          if (head.ch == CH_BSLASH) begin
            phase_next = PH_ESCAPE;
          end else begin
            have = 1'b1;
            vb = head.ch;
          end
          if (head.last) begin
            done = 1'b1;
            st = ST_OPEN;
          end
        end
      end
      PH_ESCAPE: begin
        have = 1'b1;
        vb = unescape(head.ch);
        phase_next = PH_VALUE;
        if (head.last) begin
          done = 1'b1;
          st = ST_OPEN;
        end
      end
      PH_DRAIN: begin
        phase_next = PH_DRAIN;
      end
      default: begin
        phase_next = PH_SEARCH;
      end
    endcase
    if (head.last) begin
      phase_next = PH_SEARCH;
    end else if (done) begin
      phase_next = PH_DRAIN;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_SEARCH;
      out_valid <= 1'b0;
    end else begin
      if (q_rd) begin
        phase <= phase_next;
      end
      if (pop && out_valid) begin
        out_valid <= 1'b0;
      end
      if (q_rd && (have || done)) begin
        out_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_rd && (have || done)) begin
      value_byte <= vb;
      byte_valid <= have;
      done_res <= done;
      status <= st;
    end
  end

  // Front end and back end agree on whether the key search is running
  a_search_agree: assert property (@(posedge clk) disable iff (rst)
    q_rd |-> ((phase == PH_SEARCH) == head.searching))
    else $error("front and back disagree on search phase");

  a_last_restarts: assert property (@(posedge clk) disable iff (rst)
    (q_rd && head.last) |=> (phase == PH_SEARCH))
    else $error("text end did not restart the search");

  a_result_nonempty: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (byte_valid || done_res))
    else $error("result with neither byte nor done");

  a_status_only_done: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !done_res) |-> (status == ST_NOT_FOUND))
    else $error("status set on a result that is not final");

endmodule

### sv/json_string_field_extractor.sv
// JSON string field extractor.
// Input queue port: text bytes enter one per cycle on text_byte/text_last,
// taken on a clock edge with push high and full low. text_last marks the end
// of one JSON text; the next byte starts a new text with a fresh search.
// Result queue port: while empty is low the oldest result sits on
// value_byte/byte_valid/done_res/status and leaves on an edge with pop high.
// Each text yields its decoded value bytes, then exactly one result with
// done_res set (status 0 not found, 1 complete, 2 unterminated).
// Configuration: cfg_write with cfg_index 0/1/2 loads key bytes 0-7, key
// bytes 8-15 and the key length; write only while no text is in flight.
// Timing: one byte per cycle sustained while full stays low. A taken byte is
// written into the classify queue, then decoded straight into the output
// register, from which its result can be popped.
// Stall: when pop stays low the output register holds, the back end stops,
// the classify queue fills, and full rises once four bytes wait in it.
// Reset (rst, synchronous): queues empty, search restarts, key cleared.
module json_string_field_extractor import jsfx_pkg::*; #(
  parameter int MAX_KEY_BYTES = 16
) (
  input  logic        clk,
  input  logic        rst,
  // configuration
  input  logic        cfg_write,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_data,
  // text in
  input  logic        push,
  output logic        full,
  input  logic [7:0]  text_byte,
  input  logic        text_last,
  // results out
  output logic        empty,
  input  logic        pop,
  output logic [7:0]  value_byte,
  output logic        byte_valid,
  output logic        done_res,
  output logic [1:0]  status
);

  logic [63:0] key_chars_low;
  logic [63:0] key_chars_high;
  logic [4:0]  key_length;
  logic        take;
  class_t      item;
  class_t      head;
  logic        q_empty;
  logic        q_rd;

  // Key registers
  always_ff @(posedge clk) begin
    if (rst) begin
      key_chars_low <= '0;
      key_chars_high <= '0;
      key_length <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_KEY_LOW:  key_chars_low <= cfg_data;
        REG_KEY_HIGH: key_chars_high <= cfg_data;
        REG_KEY_LEN:  key_length <= cfg_data[4:0];
        default: begin
        end
      endcase
    end
  end

  assign take = push && !full;

  // Front end: sliding key window, tags each byte
  jsfx_front #(
    .MAX_KEY_BYTES(MAX_KEY_BYTES)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .take     (take),
    .text_byte(text_byte),
    .text_last(text_last),
    .key_low  (key_chars_low),
    .key_high (key_chars_high),
    .key_len  (key_length),
    .item     (item)
  );

  // Short queue decoupling classification from value decoding
  jsfx_queue u_queue (
    .clk    (clk),
    .rst    (rst),
    .wr     (take),
    .wr_item(item),
    .rd     (q_rd),
    .head   (head),
    .q_empty(q_empty),
    .q_full (full)
  );

  // Back end: colon/whitespace/value/escape sequencing and output register
  jsfx_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (head),
    .q_empty   (q_empty),
    .q_rd      (q_rd),
    .pop       (pop),
    .empty     (empty),
    .value_byte(value_byte),
    .byte_valid(byte_valid),
    .done_res  (done_res),
    .status    (status)
  );

endmodule
